FILE: rtl/ptt_pkg.sv
package ptt_pkg;

	localparam int SLOTS = 8;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	localparam int OP_W = 3;
	localparam int TIDX_W = 3;
	localparam int MS_W = 16;
	localparam int TPS_W = 14;
	localparam int TICK_W = 16;
	localparam int ST_W = 3;
	localparam int OSLOT_W = 3;

	localparam logic [TPS_W-1:0] TPS_RESET = 14'd1000;

	// ms * tps / 1000 = ((ms * tps) >> 3) / 125, the divide done as a reciprocal multiply
	localparam int PROD_W = MS_W + TPS_W;
	localparam int MA_W = PROD_W - 3;
	localparam int MB_W = 28;
	localparam int MP_W = MA_W + MB_W;
	localparam int RECIP_SHIFT = 34;
	localparam logic [MB_W-1:0] RECIP = 28'd137438954;

	typedef enum logic [OP_W-1:0] {
		OP_TICK     = 3'd0,
		OP_ADD      = 3'd1,
		OP_ENABLE   = 3'd2,
		OP_DISABLE  = 3'd3,
		OP_SETPER   = 3'd4,
		OP_DISPATCH = 3'd5
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_NOSLOT  = 3'd3,
		ST_ZEROPER = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_MUL1,
		S_MUL2,
		S_CONV,
		S_TICK,
		S_DISP,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [TIDX_W-1:0] task_index;
		logic [MS_W-1:0]   delay_ms;
		logic [MS_W-1:0]   period_ms;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]    status;
		logic [OSLOT_W-1:0] slot;
		logic               slot_valid;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic              set_use;
		logic              set_en;
		logic              en;
		logic              set_rdy;
		logic              rdy;
		logic              set_period;
		logic              set_cd;
		logic              set_delay;
		logic [TICK_W-1:0] period;
		logic [TICK_W-1:0] cd;
		logic [TICK_W-1:0] delay;
	} tbl_wr_t;

	typedef struct packed {
		logic              in_use;
		logic              en;
		logic              rdy;
		logic [TICK_W-1:0] period;
		logic [TICK_W-1:0] cd;
		logic [TICK_W-1:0] delay;
	} tbl_rd_t;

endpackage

FILE: rtl/ptt_mul.sv
module ptt_mul (
	input  logic                      clk,
	input  logic [ptt_pkg::MA_W-1:0]  a,
	input  logic [ptt_pkg::MB_W-1:0]  b,
	output logic [ptt_pkg::MP_W-1:0]  p
);

	logic [ptt_pkg::MP_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= ptt_pkg::MP_W'(a) * ptt_pkg::MP_W'(b);
	end

	assign p = p_q;

endmodule

FILE: rtl/ptt_table.sv
module ptt_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ptt_pkg::SLOT_W-1:0]  idx,
	input  ptt_pkg::tbl_wr_t            wr,
	output ptt_pkg::tbl_rd_t            rd,
	output logic [ptt_pkg::SLOTS-1:0]   in_use,
	output logic [ptt_pkg::SLOTS-1:0]   qual,
	output logic [ptt_pkg::CNT_W-1:0]   used_count
);

	logic [ptt_pkg::TICK_W-1:0] period_q [ptt_pkg::SLOTS];
	logic [ptt_pkg::TICK_W-1:0] cd_q [ptt_pkg::SLOTS];
	logic [ptt_pkg::TICK_W-1:0] delay_q [ptt_pkg::SLOTS];
	logic [ptt_pkg::SLOTS-1:0]  in_use_q;
	logic [ptt_pkg::SLOTS-1:0]  en_q;
	logic [ptt_pkg::SLOTS-1:0]  rdy_q;
	logic [ptt_pkg::CNT_W-1:0]  used_q;

	// per-slot payload, written on its set strobes and not reset
	always_ff @(posedge clk) begin
		if (wr.set_period) begin
			period_q[idx] <= wr.period;
		end
		if (wr.set_cd) begin
			cd_q[idx] <= wr.cd;
		end
		if (wr.set_delay) begin
			delay_q[idx] <= wr.delay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			en_q <= '0;
			rdy_q <= '0;
			used_q <= '0;
		end else begin
			if (wr.set_use) begin
				in_use_q[idx] <= 1'b1;
				used_q <= used_q + ptt_pkg::CNT_W'(1);
			end
			if (wr.set_en) begin
				en_q[idx] <= wr.en;
			end
			if (wr.set_rdy) begin
				rdy_q[idx] <= wr.rdy;
			end
		end
	end

	always_comb begin
		rd.in_use = in_use_q[idx];
		rd.en = en_q[idx];
		rd.rdy = rdy_q[idx];
		rd.period = period_q[idx];
		rd.cd = cd_q[idx];
		rd.delay = delay_q[idx];
	end

	assign in_use = in_use_q;
	assign qual = in_use_q & en_q & rdy_q;
	assign used_count = used_q;

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) == $countones(in_use_q))
		else $error("used count out of step with in-use flags");

	a_add_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		wr.set_use |-> !in_use_q[idx])
		else $error("slot taken twice");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr.set_use |-> 32'(used_q) < ptt_pkg::SLOTS)
		else $error("add on a full table");

endmodule

FILE: rtl/periodic_task_timer_table.sv
// request accepted to first result: enable, disable, unused codes and requests refused at
// decode go straight to the response; set period and an add with a zero period make one pass
// and a successful add two passes through the shared 27x28 multiplier; tick sweeps every slot
// (one slot per cycle through the slot update path); dispatch walks the slots from slot 0
// throughput: one request at a time, the next taken in the cycle after the last result is loaded
// arst_n clears the sequencer, slot flags, used count and output valid; tick rate back to 1000
module periodic_task_timer_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  ptt_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output ptt_pkg::rsp_t               rsp,
	input  logic                        cfg_we,
	input  logic [ptt_pkg::TPS_W-1:0]   cfg_wdata
);

	ptt_pkg::state_t               state_q;
	ptt_pkg::state_t               state_d;
	ptt_pkg::req_t                 req_q;
	logic [ptt_pkg::SLOT_W-1:0]    idx_q;
	logic [ptt_pkg::TPS_W-1:0]     tps_q;
	logic [ptt_pkg::TICK_W-1:0]    per_q;
	logic                          conv_dly_q;
	ptt_pkg::rsp_t                 res_q;
	ptt_pkg::rsp_t                 res_dec;
	ptt_pkg::rsp_t                 out_q;
	ptt_pkg::rsp_t                 out_d;
	logic                          out_valid_q;
	logic                          load_out;
	logic                          out_free;

	logic [ptt_pkg::MA_W-1:0]      mul_a;
	logic [ptt_pkg::MB_W-1:0]      mul_b;
	logic [ptt_pkg::MP_W-1:0]      mul_p;
	logic [ptt_pkg::TICK_W-1:0]    conv;

	ptt_pkg::tbl_wr_t              tbl_wr;
	ptt_pkg::tbl_rd_t              tbl_rd;
	logic [ptt_pkg::SLOTS-1:0]     tbl_in_use;
	logic [ptt_pkg::SLOTS-1:0]     tbl_qual;
	logic [ptt_pkg::CNT_W-1:0]     used_count;

	logic [ptt_pkg::SLOT_W-1:0]    free_idx;
	logic                          table_full;
	logic [ptt_pkg::ST_W-1:0]      lk_status;
	logic                          lk_ok;
	logic                          more;
	logic                          qual_here;
	logic                          sweep_end;

	ptt_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	ptt_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.idx        (idx_q),
		.wr         (tbl_wr),
		.rd         (tbl_rd),
		.in_use     (tbl_in_use),
		.qual       (tbl_qual),
		.used_count (used_count)
	);

	assign conv = mul_p[ptt_pkg::RECIP_SHIFT +: ptt_pkg::TICK_W];
	assign out_free = !out_valid_q || rsp_ready;
	assign table_full = 32'(used_count) >= ptt_pkg::SLOTS;
	assign qual_here = tbl_qual[idx_q];
	assign sweep_end = idx_q == ptt_pkg::SLOT_W'(ptt_pkg::SLOTS - 1);
	assign lk_ok = lk_status == ptt_pkg::ST_OK;

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = ptt_pkg::SLOTS - 1; i >= 0; i--) begin
			if (!tbl_in_use[i]) begin
				free_idx = ptt_pkg::SLOT_W'(i);
			end
		end
	end

	// any dispatchable slot above the current one
	always_comb begin
		more = 1'b0;
		for (int i = 0; i < ptt_pkg::SLOTS; i++) begin
			if (tbl_qual[i] && (ptt_pkg::SLOT_W'(i) > idx_q)) begin
				more = 1'b1;
			end
		end
	end

	always_comb begin
		if (used_count == '0) begin
			lk_status = ptt_pkg::ST_EMPTY;
		end else if (32'(req_q.task_index) >= ptt_pkg::SLOTS) begin
			lk_status = ptt_pkg::ST_NOSLOT;
		end else if (!tbl_rd.in_use) begin
			lk_status = ptt_pkg::ST_NOSLOT;
		end else begin
			lk_status = ptt_pkg::ST_OK;
		end
	end

	always_comb begin
		res_dec = '{status: ptt_pkg::ST_OK, slot: '0, slot_valid: 1'b0, last: 1'b1};
		case (req_q.operation) inside
			ptt_pkg::OP_ADD: begin
				if (table_full) begin
					res_dec.status = ptt_pkg::ST_FULL;
				end
			end
			ptt_pkg::OP_ENABLE, ptt_pkg::OP_DISABLE, ptt_pkg::OP_SETPER: begin
				res_dec.status = lk_status;
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptt_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = ptt_pkg::S_DEC;
				end
			end
			ptt_pkg::S_DEC: begin
				unique case (req_q.operation)
					ptt_pkg::OP_TICK: state_d = ptt_pkg::S_TICK;
					ptt_pkg::OP_DISPATCH: state_d = ptt_pkg::S_DISP;
					ptt_pkg::OP_ADD: state_d = table_full ? ptt_pkg::S_RESP : ptt_pkg::S_MUL1;
					ptt_pkg::OP_SETPER: state_d = lk_ok ? ptt_pkg::S_MUL1 : ptt_pkg::S_RESP;
					default: state_d = ptt_pkg::S_RESP;
				endcase
			end
			ptt_pkg::S_MUL1: state_d = ptt_pkg::S_MUL2;
			ptt_pkg::S_MUL2: state_d = ptt_pkg::S_CONV;
			ptt_pkg::S_CONV: begin
				if (conv_dly_q || conv == '0 || req_q.operation == ptt_pkg::OP_SETPER) begin
					state_d = ptt_pkg::S_RESP;
				end else begin
					state_d = ptt_pkg::S_MUL1;
				end
			end
			ptt_pkg::S_TICK: begin
				if (sweep_end) begin
					state_d = ptt_pkg::S_RESP;
				end
			end
			ptt_pkg::S_DISP: begin
				if (qual_here) begin
					if (out_free && !more) begin
						state_d = ptt_pkg::S_IDLE;
					end
				end else if (!more) begin
					state_d = ptt_pkg::S_RESP;
				end
			end
			ptt_pkg::S_RESP: begin
				if (out_free) begin
					state_d = ptt_pkg::S_IDLE;
				end
			end
			default: state_d = ptt_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		tbl_wr = '0;
		load_out = 1'b0;
		out_d = res_q;
		req_ready = 1'b0;
		mul_a = mul_p[ptt_pkg::PROD_W-1:3];
		mul_b = ptt_pkg::RECIP;
		unique case (state_q)
			ptt_pkg::S_IDLE: begin
				req_ready = 1'b1;
			end
			ptt_pkg::S_DEC: begin
				if ((req_q.operation == ptt_pkg::OP_ENABLE ||
				     req_q.operation == ptt_pkg::OP_DISABLE) && lk_ok) begin
					tbl_wr.set_en = 1'b1;
					tbl_wr.en = req_q.operation == ptt_pkg::OP_ENABLE;
				end
			end
			ptt_pkg::S_MUL1: begin
				mul_a = ptt_pkg::MA_W'(conv_dly_q ? req_q.delay_ms : req_q.period_ms);
				mul_b = ptt_pkg::MB_W'(tps_q);
			end
			ptt_pkg::S_MUL2: begin
			end
			ptt_pkg::S_CONV: begin
				if (conv_dly_q) begin
					tbl_wr.set_use = 1'b1;
					tbl_wr.set_period = 1'b1;
					tbl_wr.period = per_q;
					tbl_wr.set_cd = 1'b1;
					tbl_wr.cd = per_q;
					tbl_wr.set_delay = 1'b1;
					tbl_wr.delay = conv;
					tbl_wr.set_en = 1'b1;
					tbl_wr.en = 1'b1;
					tbl_wr.set_rdy = 1'b1;
					tbl_wr.rdy = 1'b0;
				end else if (conv != '0 && req_q.operation == ptt_pkg::OP_SETPER) begin
					tbl_wr.set_period = 1'b1;
					tbl_wr.period = conv;
				end
			end
			ptt_pkg::S_TICK: begin
				if (tbl_rd.in_use) begin
					if (tbl_rd.delay != '0) begin
						tbl_wr.set_delay = 1'b1;
						tbl_wr.delay = tbl_rd.delay - ptt_pkg::TICK_W'(1);
					end else begin
						tbl_wr.set_cd = 1'b1;
						tbl_wr.cd = tbl_rd.cd - ptt_pkg::TICK_W'(1);
						if (tbl_rd.cd == ptt_pkg::TICK_W'(1)) begin
							tbl_wr.set_rdy = 1'b1;
							tbl_wr.rdy = 1'b1;
						end
					end
				end
			end
			ptt_pkg::S_DISP: begin
				if (qual_here && out_free) begin
					tbl_wr.set_rdy = 1'b1;
					tbl_wr.rdy = 1'b0;
					tbl_wr.set_cd = 1'b1;
					tbl_wr.cd = tbl_rd.period;
					load_out = 1'b1;
					out_d.status = ptt_pkg::ST_OK;
					out_d.slot = ptt_pkg::OSLOT_W'(idx_q);
					out_d.slot_valid = 1'b1;
					out_d.last = !more;
				end
			end
			ptt_pkg::S_RESP: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptt_pkg::S_IDLE;
			tps_q <= ptt_pkg::TPS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				tps_q <= cfg_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and sequencer payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= out_d;
		end
		unique case (state_q)
			ptt_pkg::S_IDLE: begin
				req_q <= req;
				conv_dly_q <= 1'b0;
				case (req.operation) inside
					ptt_pkg::OP_ENABLE, ptt_pkg::OP_DISABLE, ptt_pkg::OP_SETPER: begin
						idx_q <= ptt_pkg::SLOT_W'(req.task_index);
					end
					ptt_pkg::OP_ADD: idx_q <= free_idx;
					default: idx_q <= '0;
				endcase
			end
			ptt_pkg::S_DEC: begin
				res_q <= res_dec;
			end
			ptt_pkg::S_CONV: begin
				if (conv_dly_q) begin
					res_q.slot <= ptt_pkg::OSLOT_W'(idx_q);
					res_q.slot_valid <= 1'b1;
				end else if (conv == '0) begin
					res_q.status <= ptt_pkg::ST_ZEROPER;
				end else begin
					per_q <= conv;
					conv_dly_q <= 1'b1;
				end
			end
			ptt_pkg::S_TICK: begin
				idx_q <= idx_q + ptt_pkg::SLOT_W'(1);
			end
			ptt_pkg::S_DISP: begin
				if (!qual_here || out_free) begin
					idx_q <= idx_q + ptt_pkg::SLOT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free)
		else $error("result overwritten before it was taken");

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q == ptt_pkg::S_DEC)
		else $error("accepted request not decoded");

	a_dispatch_qualified: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ptt_pkg::S_DISP && load_out |-> tbl_qual[idx_q])
		else $error("dispatched a slot that is not ready and enabled");

endmodule

FILE: tb/sv/tb_periodic_task_timer_table.sv
module tb_periodic_task_timer_table;
	timeunit 1ns;
	timeprecision 1ps;

	import ptt_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

	class task_table_tracker;
		logic [TICK_W-1:0] period_ticks [SLOTS];
		logic [TICK_W-1:0] countdown [SLOTS];
		logic [TICK_W-1:0] start_delay [SLOTS];
		bit in_use [SLOTS];
		bit enabled [SLOTS];
		bit ready [SLOTS];
		int used;
		int tps;
		rsp_t due_results [$];
		int errors;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				period_ticks[i] = '0;
				countdown[i] = '0;
				start_delay[i] = '0;
				in_use[i] = 1'b0;
				enabled[i] = 1'b0;
				ready[i] = 1'b0;
			end
			used = 0;
			tps = TPS_RESET;
			errors = 0;
		endfunction

		function logic [TICK_W-1:0] to_ticks(logic [MS_W-1:0] ms);
			logic [47:0] prod;
			prod = 48'(ms) * 48'(tps);
			return TICK_W'(prod / 1000);
		endfunction

		function void queue_result(status_t st, int slot, bit valid, bit last);
			rsp_t r;
			r.status = st;
			r.slot = OSLOT_W'(slot);
			r.slot_valid = valid;
			r.last = last;
			due_results.push_back(r);
		endfunction

		function status_t find_slot(int idx);
			if (used == 0)
				return ST_EMPTY;
			if (idx >= SLOTS || !in_use[idx])
				return ST_NOSLOT;
			return ST_OK;
		endfunction

		function void note_request(req_t r);
			int idx;
			int hits;
			int free_slot;
			status_t st;
			logic [TICK_W-1:0] per;
			rsp_t tail;
			idx = r.task_index;
			hits = 0;
			free_slot = -1;
			case (r.operation)
				OP_TICK: begin
					for (int i = 0; i < SLOTS; i++) begin
						if (in_use[i]) begin
							if (start_delay[i] != 0) begin
								start_delay[i] = start_delay[i] - 1'b1;
							end else begin
								countdown[i] = countdown[i] - 1'b1;
								if (countdown[i] == 0)
									ready[i] = 1'b1;
							end
						end
					end
					queue_result(ST_OK, 0, 1'b0, 1'b1);
				end
				OP_ADD: begin
					per = to_ticks(r.period_ms);
					for (int i = SLOTS - 1; i >= 0; i--)
						if (!in_use[i])
							free_slot = i;
					if (used >= SLOTS || free_slot < 0) begin
						queue_result(ST_FULL, 0, 1'b0, 1'b1);
					end else if (per == 0) begin
						queue_result(ST_ZEROPER, 0, 1'b0, 1'b1);
					end else begin
						in_use[free_slot] = 1'b1;
						period_ticks[free_slot] = per;
						countdown[free_slot] = per;
						start_delay[free_slot] = to_ticks(r.delay_ms);
						enabled[free_slot] = 1'b1;
						ready[free_slot] = 1'b0;
						used++;
						queue_result(ST_OK, free_slot, 1'b1, 1'b1);
					end
				end
				OP_ENABLE, OP_DISABLE: begin
					st = find_slot(idx);
					if (st == ST_OK)
						enabled[idx] = (r.operation == OP_ENABLE);
					queue_result(st, 0, 1'b0, 1'b1);
				end
				OP_SETPER: begin
					st = find_slot(idx);
					if (st == ST_OK) begin
						per = to_ticks(r.period_ms);
						if (per == 0)
							st = ST_ZEROPER;
						else
							period_ticks[idx] = per;
					end
					queue_result(st, 0, 1'b0, 1'b1);
				end
				OP_DISPATCH: begin
					for (int i = 0; i < SLOTS; i++) begin
						if (in_use[i] && ready[i] && enabled[i]) begin
							ready[i] = 1'b0;
							countdown[i] = period_ticks[i];
							queue_result(ST_OK, i, 1'b1, 1'b0);
							hits++;
						end
					end
					if (hits == 0) begin
						queue_result(ST_OK, 0, 1'b0, 1'b1);
					end else begin
						tail = due_results.pop_back();
						tail.last = 1'b1;
						due_results.push_back(tail);
					end
				end
				default: begin
					queue_result(ST_OK, 0, 1'b0, 1'b1);
				end
			endcase
		endfunction

		function void field_check(string name, logic [2:0] want, logic [2:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected result, expected none, actual %h", $time, got);
				return;
			end
			want = due_results.pop_front();
			field_check("status", want.status, got.status);
			field_check("slot", want.slot, got.slot);
			field_check("slot_valid", 3'(want.slot_valid), 3'(got.slot_valid));
			field_check("last", 3'(want.last), 3'(got.last));
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [TPS_W-1:0] cfg_wdata = '0;
	bit steady_src = 1'b0;
	bit steady_sink = 1'b0;
	task_table_tracker tracker = new();

	periodic_task_timer_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("simulation failed");
		$finish;
	end

	function automatic req_t make_req(logic [OP_W-1:0] op, int idx, int dly, int per);
		req_t r;
		r.operation = op;
		r.task_index = TIDX_W'(idx);
		r.delay_ms = MS_W'(dly);
		r.period_ms = MS_W'(per);
		return r;
	endfunction

	// milliseconds that give at least the wanted tick count at the current rate
	function automatic int ms_for_ticks(int ticks);
		return (ticks * 1000 + tracker.tps - 1) / tracker.tps;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 34)
			r.operation = OP_TICK;
		else if (pick < 54)
			r.operation = OP_DISPATCH;
		else if (pick < 62)
			r.operation = OP_ADD;
		else if (pick < 70)
			r.operation = OP_ENABLE;
		else if (pick < 76)
			r.operation = OP_DISABLE;
		else if (pick < 94)
			r.operation = OP_SETPER;
		else if (pick < 97)
			r.operation = OP_SPARE_A;
		else
			r.operation = OP_SPARE_B;
		r.task_index = TIDX_W'($urandom_range(0, 7));
		pick = $urandom_range(0, 99);
		if (pick < 5)
			r.delay_ms = MS_W'($urandom);
		else if (pick < 40)
			r.delay_ms = '0;
		else
			r.delay_ms = MS_W'(ms_for_ticks($urandom_range(1, 4)));
		pick = $urandom_range(0, 99);
		if (pick < 6)
			r.period_ms = MS_W'($urandom);
		else if (pick < 10)
			r.period_ms = '0;
		else
			r.period_ms = MS_W'(ms_for_ticks($urandom_range(1, 6)));
		return r;
	endfunction

	task automatic send_request(input req_t r);
		int gap;
		gap = steady_src ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		tracker.note_request(r);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (tracker.due_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_rate(input int rate);
		cfg_we <= 1'b1;
		cfg_wdata <= TPS_W'(rate);
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.tps = rate;
	endtask

	initial begin
		int stall;
		wait (arst_n == 1'b1);
		@(posedge clk);
		forever begin
			stall = steady_sink ? 0 : $urandom_range(0, 6);
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			tracker.check_result(rsp);
		end
	end

	initial begin
		int phase_rate [5];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, then first slots at the reset rate
		send_request(make_req(OP_DISPATCH, 0, 0, 0));
		send_request(make_req(OP_ENABLE, 0, 0, 0));
		send_request(make_req(OP_SETPER, 3, 0, 5));
		send_request(make_req(OP_ADD, 0, 0, 0));
		send_request(make_req(OP_ADD, 0, 0, 2));
		send_request(make_req(OP_ADD, 0, 2, 1));
		send_request(make_req(OP_DISABLE, 5, 0, 0));
		send_request(make_req(OP_SETPER, 6, 0, 0));
		send_request(make_req(OP_SETPER, 0, 0, 0));
		send_request(make_req(OP_TICK, 0, 0, 0));
		send_request(make_req(OP_TICK, 0, 0, 0));
		send_request(make_req(OP_DISABLE, 0, 0, 0));
		send_request(make_req(OP_TICK, 0, 0, 0));
		send_request(make_req(OP_DISPATCH, 0, 0, 0));
		send_request(make_req(OP_ENABLE, 0, 0, 0));
		send_request(make_req(OP_SETPER, 1, 0, 65535));
		send_request(make_req(OP_DISPATCH, 0, 0, 0));

		// fastest rate: truncation to 16 bits
		wait_idle();
		write_rate(10000);
		send_request(make_req(OP_ADD, 0, 0, 32768));
		send_request(make_req(OP_ADD, 0, 1, 1));
		send_request(make_req(OP_SETPER, 2, 0, 65535));
		send_request(make_req(OP_SETPER, 1, 0, 3));

		// slowest rate, then fill the table
		wait_idle();
		write_rate(1);
		send_request(make_req(OP_ADD, 0, 0, 999));
		send_request(make_req(OP_ADD, 0, 65535, 1000));
		for (int k = 0; k < 5; k++)
			send_request(make_req(OP_ADD, 0, 1000, 2000));

		phase_rate = '{1000, 10000, 1, 1, 1};
		phase_rate[3] = $urandom_range(1, 10000);
		phase_rate[4] = $urandom_range(1, 10000);
		for (int p = 0; p < 5; p++) begin
			wait_idle();
			write_rate(phase_rate[p]);
			for (int n = 0; n < 60; n++) begin
				if (n % 20 == 0) begin
					steady_src = ($urandom_range(0, 3) == 0);
					steady_sink = ($urandom_range(0, 3) == 0);
				end
				send_request(random_request());
			end
		end

		wait_idle();
		if (tracker.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
